[sv/dbh_pkg.sv]
package dbh_pkg;

  localparam int unsigned HoldSlots   = 4;
  localparam int unsigned UnchWidth   = 16;
  localparam int unsigned HeldWidth   = 24;
  localparam int unsigned CfgIdxWidth = 4;
  localparam int unsigned CfgDatWidth = 24;
  localparam int unsigned InDatWidth  = 8;
  localparam int unsigned OutDatWidth = 8;

  // register indexes on the configuration channel
  localparam logic [CfgIdxWidth-1:0] RegActiveLevel   = 4'd0;
  localparam logic [CfgIdxWidth-1:0] RegDebounceTicks = 4'd1;
  localparam logic [CfgIdxWidth-1:0] RegHoldTimeA     = 4'd2;
  localparam logic [CfgIdxWidth-1:0] RegHoldTimeB     = 4'd3;
  localparam logic [CfgIdxWidth-1:0] RegHoldTimeC     = 4'd4;
  localparam logic [CfgIdxWidth-1:0] RegHoldTimeD     = 4'd5;
  localparam logic [CfgIdxWidth-1:0] RegHoldLevelMask = 4'd6;
  localparam logic [CfgIdxWidth-1:0] RegHoldEnMask    = 4'd7;

  localparam logic [UnchWidth-1:0] DebounceReset = 16'd50;

  typedef struct packed {
    logic                                active_level;
    logic [UnchWidth-1:0]                debounce_ticks;
    logic [HoldSlots-1:0][HeldWidth-1:0] hold_time;
    logic [HoldSlots-1:0]                hold_level_mask;
    logic [HoldSlots-1:0]                hold_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic [HoldSlots-1:0] hold_fired;
    logic                 became_inactive;
    logic                 became_active;
    logic                 changed;
    logic                 stable_active;
  } res_t;

endpackage

[sv/dbh_cfg.sv]
module dbh_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [dbh_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [dbh_pkg::CfgDatWidth-1:0]     cfg_data_i,
  output dbh_pkg::cfg_t                       cfg_o
);

  dbh_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dbh_pkg::RegActiveLevel:   cfg_d.active_level = cfg_data_i[0];
        dbh_pkg::RegDebounceTicks: cfg_d.debounce_ticks = cfg_data_i[dbh_pkg::UnchWidth-1:0];
        dbh_pkg::RegHoldTimeA:     cfg_d.hold_time[0] = cfg_data_i[dbh_pkg::HeldWidth-1:0];
        dbh_pkg::RegHoldTimeB:     cfg_d.hold_time[1] = cfg_data_i[dbh_pkg::HeldWidth-1:0];
        dbh_pkg::RegHoldTimeC:     cfg_d.hold_time[2] = cfg_data_i[dbh_pkg::HeldWidth-1:0];
        dbh_pkg::RegHoldTimeD:     cfg_d.hold_time[3] = cfg_data_i[dbh_pkg::HeldWidth-1:0];
        dbh_pkg::RegHoldLevelMask: begin
          cfg_d.hold_level_mask = cfg_data_i[dbh_pkg::HoldSlots-1:0];
        end
        dbh_pkg::RegHoldEnMask: begin
          cfg_d.hold_enable_mask = cfg_data_i[dbh_pkg::HoldSlots-1:0];
        end
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level     <= 1'b0;
      cfg_q.debounce_ticks   <= dbh_pkg::DebounceReset;
      cfg_q.hold_time        <= '0;
      cfg_q.hold_level_mask  <= '0;
      cfg_q.hold_enable_mask <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/dbh_core.sv]
module dbh_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          raw_i,
  input  dbh_pkg::cfg_t cfg_i,
  output dbh_pkg::res_t res_o
);

  logic                            last_raw_q, last_raw_d;
  logic                            stable_raw_q, stable_raw_d;
  logic [dbh_pkg::UnchWidth-1:0]   unch_q, unch_d;
  logic [dbh_pkg::HeldWidth-1:0]   held_q, held_d;
  logic [dbh_pkg::HoldSlots-1:0]   done_q, done_d, done_mid, watch, fired;
  logic                            take, now_active, stable_act;

  always_comb begin
    last_raw_d = raw_i;
    if (raw_i != last_raw_q) begin
      unch_d = '0;
    end else if (unch_q != '1) begin
      unch_d = unch_q + 1'b1;
    end else begin
      unch_d = unch_q;
    end

    take       = (unch_d >= cfg_i.debounce_ticks) && (raw_i != stable_raw_q);
    now_active = (raw_i == cfg_i.active_level);
    watch      = now_active ? cfg_i.hold_level_mask : ~cfg_i.hold_level_mask;

    if (take) begin
      held_d       = '0;
      stable_raw_d = raw_i;
      done_mid     = done_q & ~watch;  // rearm slots watching the new level
    end else begin
      held_d       = (held_q != '1) ? held_q + 1'b1 : held_q;
      stable_raw_d = stable_raw_q;
      done_mid     = done_q;
    end

    stable_act = (stable_raw_d == cfg_i.active_level);

    for (int i = 0; i < dbh_pkg::HoldSlots; i++) begin
      fired[i] = cfg_i.hold_enable_mask[i] && (cfg_i.hold_level_mask[i] == stable_act)
                 && !done_mid[i] && (held_d >= cfg_i.hold_time[i]);
    end
    done_d = done_mid | fired;

    res_o.stable_active   = stable_act;
    res_o.changed         = take;
    res_o.became_active   = take && now_active;
    res_o.became_inactive = take && !now_active;
    res_o.hold_fired      = fired;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q   <= 1'b0;
      stable_raw_q <= 1'b0;
      unch_q       <= '0;
      held_q       <= '0;
      done_q       <= '1;
    end else if (step_i) begin
      last_raw_q   <= last_raw_d;
      stable_raw_q <= stable_raw_d;
      unch_q       <= unch_d;
      held_q       <= held_d;
      done_q       <= done_d;
    end
  end

endmodule

[sv/debounced_input_with_hold_events.sv]
// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+--------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready   | tdata[0] raw_level
// m_axis    | out       | m_axis_tvalid / m_axis_tready   | tdata[0] stable_active, [1] changed,
//           |           |                                 | [2] became_active, [3] became_inactive,
//           |           |                                 | [7:4] hold_fired
// cfg       | in        | cfg_valid_i / cfg_ready_o       | cfg_index_i, cfg_data_i
//
// Each item passes from acceptance to result through the input register and then
// the result register. The step logic (two counters, a debounce compare and
// four 24-bit threshold compares) sits between them, so one item per cycle is sustained while m_axis is not stalled.
// Reset clears the debounce and hold state, with every hold slot marked done, and
// loads the register defaults. A stalled output holds its result while the input
// register still takes a new item; the input only stalls once both registers are full.
module debounced_input_with_hold_events (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream: tdata = raw_level (bit 0), rest zero
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dbh_pkg::InDatWidth-1:0]      s_axis_tdata,
  // master stream: tdata = stable_active, changed, became_active, became_inactive,
  //                hold_fired[3:0] (from bit 0 up)
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dbh_pkg::OutDatWidth-1:0]     m_axis_tdata,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dbh_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [dbh_pkg::CfgDatWidth-1:0]     cfg_data_i
);

  dbh_pkg::cfg_t cfg;
  dbh_pkg::res_t res;

  logic          in_valid_q, in_valid_d;
  logic          in_raw_q;
  logic          out_valid_q, out_valid_d;
  dbh_pkg::res_t out_res_q;
  logic          step, s_take;

  // register writes are always taken and are registered in dbh_cfg
  assign cfg_ready_o = 1'b1;

  dbh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // advance the held item once the result register is free or being drained
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  dbh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .raw_i  (in_raw_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: hold until a new item lands
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_raw_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

endmodule
